// ===== hdl/smbb_pkg.sv =====
// Shared types, constants and helper functions for the scaled mono bitmap blitter.
// Holds the microcode program, control/status structs and configuration layout.
// No dependencies.
package smbb_pkg;

  localparam int MAX_SRC_DIM = 64;
  localparam int MAX_OUT_DIM = 64;
  localparam int STORE_BYTES = 512;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int DIM_W    = 7;
  localparam int ODIM_W   = $clog2(MAX_OUT_DIM) + 1;
  localparam int IDX_W    = $clog2(MAX_OUT_DIM);
  localparam int SIDX_W   = $clog2(MAX_SRC_DIM);
  localparam int STRIDE_W = $clog2((MAX_SRC_DIM + 7) / 8) + 1;
  localparam int RB_W     = SIDX_W + STRIDE_W;
  localparam int SCALE_W  = 12;
  localparam int REM_W    = SCALE_W + 1;
  localparam int PROD_W   = DIM_W + SCALE_W;
  localparam int DISP_W   = 9;
  localparam int CDIFF_W  = DISP_W + 2;
  localparam int COORD_W  = 16;
  localparam int MASK_W   = MAX_OUT_DIM;
  localparam int COLOR_W  = 2;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = SCALE_W;
  localparam int ONE_Q8   = 256;

  localparam logic [CIDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BITMAP_WIDTH   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BITMAP_HEIGHT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SCALE_Q8       = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DRAW_COLOR     = 3'd5;

  typedef struct packed {
    logic [DISP_W-1:0]  display_width;
    logic [DISP_W-1:0]  display_height;
    logic [DIM_W-1:0]   bitmap_width;
    logic [DIM_W-1:0]   bitmap_height;
    logic [SCALE_W-1:0] scale_q8;
    logic [COLOR_W-1:0] draw_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    display_width:  9'd128,
    display_height: 9'd64,
    bitmap_width:   7'd64,
    bitmap_height:  7'd64,
    scale_q8:       12'd256,
    draw_color:     2'd1
  };

  typedef logic [2:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [2:0] upc_t;

  localparam op_t OP_WAIT    = 3'd0;
  localparam op_t OP_SIZE    = 3'd1;
  localparam op_t OP_PLACE   = 3'd2;
  localparam op_t OP_ROWSEL  = 3'd3;
  localparam op_t OP_COLS    = 3'd4;
  localparam op_t OP_EMIT    = 3'd5;
  localparam op_t OP_NEXTROW = 3'd6;
  localparam op_t OP_NOP     = 3'd7;

  localparam cond_t C_ALWAYS  = 3'd0;
  localparam cond_t C_GO      = 3'd1;
  localparam cond_t C_EMPTY   = 3'd2;
  localparam cond_t C_YSET    = 3'd3;
  localparam cond_t C_COLDONE = 3'd4;
  localparam cond_t C_OUTFREE = 3'd5;
  localparam cond_t C_NOTLAST = 3'd6;

  localparam upc_t UPC_IDLE   = 3'd0;
  localparam upc_t UPC_SIZE   = 3'd1;
  localparam upc_t UPC_PLACE  = 3'd2;
  localparam upc_t UPC_ROWSEL = 3'd3;
  localparam upc_t UPC_COLS   = 3'd4;
  localparam upc_t UPC_EMIT   = 3'd5;
  localparam upc_t UPC_NEXT   = 3'd6;
  localparam upc_t UPC_DONE   = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  hold;
  } uword_t;

  typedef struct packed {
    logic go;
    logic empty;
    logic y_settled;
    logic col_done;
    logic out_free;
    logic not_last;
  } stat_t;

  function automatic uword_t uc_rom(input upc_t pc);
    uword_t w;
    case (pc)
      UPC_IDLE:   w = '{op: OP_WAIT,    cond: C_GO,      target: UPC_SIZE,   hold: 1'b1};
      UPC_SIZE:   w = '{op: OP_SIZE,    cond: C_ALWAYS,  target: UPC_PLACE,  hold: 1'b0};
      UPC_PLACE:  w = '{op: OP_PLACE,   cond: C_EMPTY,   target: UPC_IDLE,   hold: 1'b0};
      UPC_ROWSEL: w = '{op: OP_ROWSEL,  cond: C_YSET,    target: UPC_COLS,   hold: 1'b1};
      UPC_COLS:   w = '{op: OP_COLS,    cond: C_COLDONE, target: UPC_EMIT,   hold: 1'b1};
      UPC_EMIT:   w = '{op: OP_EMIT,    cond: C_OUTFREE, target: UPC_NEXT,   hold: 1'b1};
      UPC_NEXT:   w = '{op: OP_NEXTROW, cond: C_NOTLAST, target: UPC_ROWSEL, hold: 1'b0};
      UPC_DONE:   w = '{op: OP_NOP,     cond: C_ALWAYS,  target: UPC_IDLE,   hold: 1'b0};
      default:    w = '{op: OP_NOP,     cond: C_ALWAYS,  target: UPC_IDLE,   hold: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_SRC_DIM)) begin
      r = DIM_W'(MAX_SRC_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [ODIM_W-1:0] scaled_dim(input logic [DIM_W-1:0] d,
                                                   input logic [SCALE_W-1:0] s);
    logic [PROD_W-1:0] p;
    logic [PROD_W-9:0] q;
    logic [ODIM_W-1:0] r;
    p = PROD_W'(d) * PROD_W'(s);
    q = p[PROD_W-1:8];
    if (q > (PROD_W-8)'(MAX_OUT_DIM)) begin
      r = ODIM_W'(MAX_OUT_DIM);
    end else begin
      r = q[ODIM_W-1:0];
    end
    return r;
  endfunction

  // (display - scaled) / 2, rounded toward zero
  function automatic logic signed [COORD_W-1:0] center_off(input logic [DISP_W-1:0] disp,
                                                           input logic [ODIM_W-1:0] sz);
    logic signed [CDIFF_W-1:0] diff;
    logic signed [CDIFF_W-1:0] half;
    diff = $signed(CDIFF_W'(disp)) - $signed(CDIFF_W'(sz));
    if (diff[CDIFF_W-1]) begin
      half = (diff + $signed(CDIFF_W'(1))) >>> 1;
    end else begin
      half = diff >>> 1;
    end
    return {{(COORD_W-CDIFF_W){half[CDIFF_W-1]}}, half};
  endfunction

endpackage

// ===== hdl/smbb_ifs.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on smbb_pkg.
interface smbb_in_if;
  import smbb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ADDR_W-1:0]         byte_index;
  logic [BYTE_W-1:0]         byte_value;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic                      center_x;
  logic                      center_y;

  modport source (output valid, mode, byte_index, byte_value, pos_x, pos_y, center_x,
                  center_y, input ready);
  modport sink (input valid, mode, byte_index, byte_value, pos_x, pos_y, center_x,
                center_y, output ready);
endinterface

interface smbb_out_if;
  import smbb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] row_y;
  logic signed [COORD_W-1:0] start_x;
  logic [MASK_W-1:0]         pixel_mask;
  logic [COLOR_W-1:0]        pixel_color;
  logic                      last;

  modport source (output valid, row_y, start_x, pixel_mask, pixel_color, last,
                  input ready);
  modport sink (input valid, row_y, start_x, pixel_mask, pixel_color, last,
                output ready);
endinterface

// ===== hdl/smbb_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on smbb_pkg.
module smbb_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  smbb_pkg::stat_t stat,
  output smbb_pkg::op_t   op
);
  import smbb_pkg::*;

  upc_t   pc_r, pc_nxt;
  uword_t word;
  logic   taken;

  assign word = uc_rom(pc_r);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      C_ALWAYS:  taken = 1'b1;
      C_GO:      taken = stat.go;
      C_EMPTY:   taken = stat.empty;
      C_YSET:    taken = stat.y_settled;
      C_COLDONE: taken = stat.col_done;
      C_OUTFREE: taken = stat.out_free;
      C_NOTLAST: taken = stat.not_last;
      default:   taken = 1'b1;
    endcase
    if (taken) begin
      pc_nxt = word.target;
    end else if (word.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/smbb_dpath.sv =====
// Datapath: bitmap store, scaling walkers, row mask build and result register.
// Depends on smbb_pkg and smbb_ifs; driven by the op code from smbb_useq.
module smbb_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  smbb_pkg::cfg_t  cfg,
  input  smbb_pkg::op_t   op,
  output smbb_pkg::stat_t stat,
  smbb_in_if.sink         in_ch,
  smbb_out_if.source      out_ch
);
  import smbb_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] mem_q_r;
  logic [ADDR_W-1:0] rd_addr;

  logic signed [COORD_W-1:0] pos_x_r, pos_y_r;
  logic                      cen_x_r, cen_y_r;
  logic [ODIM_W-1:0]         sw_r, sw_nxt, sh_r, sh_nxt;
  logic [STRIDE_W-1:0]       stride_r, stride_nxt;
  logic signed [COORD_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic [SIDX_W-1:0]         sy_r, sy_nxt, sx_r, sx_nxt;
  logic [REM_W-1:0]          ry_r, ry_nxt, rx_r, rx_nxt;
  logic [ADDR_W-1:0]         row_base_r, row_base_nxt;
  logic [ODIM_W-1:0]         i_r, i_nxt;
  logic [MASK_W-1:0]         mask_r, mask_nxt;
  logic                      pend_r, pend_nxt;
  logic [IDX_W-1:0]          pidx_r;
  logic [2:0]                pbsel_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] row_y_r, start_x_r;
  logic [MASK_W-1:0]         pmask_r;
  logic [COLOR_W-1:0]        color_r;
  logic                      last_r;

  logic [DIM_W-1:0]  bw_c, bh_c;
  logic [SIDX_W-1:0] bw_m1, bh_m1;
  logic [RB_W-1:0]   rb_full;
  logic              go, load_go, row_adv, col_adv, issue, out_free, last_row, pix_bit;

  assign in_ch.ready = (op == OP_WAIT);
  assign go          = in_ch.valid && in_ch.ready && in_ch.mode;
  assign load_go     = in_ch.valid && in_ch.ready && !in_ch.mode;

  assign bw_c    = clamp_dim(cfg.bitmap_width);
  assign bh_c    = clamp_dim(cfg.bitmap_height);
  assign bw_m1   = SIDX_W'(bw_c - DIM_W'(1));
  assign bh_m1   = SIDX_W'(bh_c - DIM_W'(1));
  assign rb_full = RB_W'(sy_r) * RB_W'(stride_r);

  assign row_adv  = (ry_r >= REM_W'(cfg.scale_q8)) && (sy_r != bh_m1);
  assign col_adv  = (rx_r >= REM_W'(cfg.scale_q8)) && (sx_r != bw_m1);
  assign issue    = (op == OP_COLS) && (i_r != sw_r) && !col_adv;
  assign rd_addr  = row_base_r + ADDR_W'(sx_r[SIDX_W-1:3]);
  assign out_free = !out_valid_r || out_ch.ready;
  assign last_row = (ODIM_W'(j_r) + ODIM_W'(1)) == sh_r;
  // MSB of a byte is the leftmost pixel
  assign pix_bit  = mem_q_r[~pbsel_r];

  assign stat = '{
    go:        go,
    empty:     (sw_r == '0) || (sh_r == '0),
    y_settled: !row_adv,
    col_done:  (i_r == sw_r) && !pend_r,
    out_free:  out_free,
    not_last:  !last_row
  };

  always_comb begin
    sw_nxt        = sw_r;
    sh_nxt        = sh_r;
    stride_nxt    = stride_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    j_nxt         = j_r;
    sy_nxt        = sy_r;
    ry_nxt        = ry_r;
    row_base_nxt  = row_base_r;
    i_nxt         = i_r;
    sx_nxt        = sx_r;
    rx_nxt        = rx_r;
    mask_nxt      = mask_r;
    pend_nxt      = issue;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pend_r) begin
      mask_nxt[pidx_r] = mask_r[pidx_r] | pix_bit;
    end
    case (op)
      OP_SIZE: begin
        sw_nxt = scaled_dim(bw_c, cfg.scale_q8);
        sh_nxt = scaled_dim(bh_c, cfg.scale_q8);
      end
      OP_PLACE: begin
        stride_nxt = STRIDE_W'((DIM_W + 1)'(bw_c) + (DIM_W + 1)'(7) >> 3);
        x0_nxt     = cen_x_r ? center_off(cfg.display_width, sw_r) : pos_x_r;
        y0_nxt     = cen_y_r ? center_off(cfg.display_height, sh_r) : pos_y_r;
        j_nxt      = '0;
        sy_nxt     = '0;
        ry_nxt     = '0;
      end
      OP_ROWSEL: begin
        if (row_adv) begin
          ry_nxt = ry_r - REM_W'(cfg.scale_q8);
          sy_nxt = sy_r + SIDX_W'(1);
        end else begin
          row_base_nxt = rb_full[ADDR_W-1:0];
          i_nxt        = '0;
          sx_nxt       = '0;
          rx_nxt       = '0;
          mask_nxt     = '0;
        end
      end
      OP_COLS: begin
        if (i_r != sw_r) begin
          if (col_adv) begin
            rx_nxt = rx_r - REM_W'(cfg.scale_q8);
            sx_nxt = sx_r + SIDX_W'(1);
          end else begin
            i_nxt = i_r + ODIM_W'(1);
            if (sx_r != bw_m1) begin
              rx_nxt = rx_r + REM_W'(ONE_Q8);
            end
          end
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      OP_NEXTROW: begin
        if (!last_row) begin
          j_nxt = j_r + IDX_W'(1);
          if (sy_r != bh_m1) begin
            ry_nxt = ry_r + REM_W'(ONE_Q8);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      mem[in_ch.byte_index] <= in_ch.byte_value;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pos_x_r <= in_ch.pos_x;
      pos_y_r <= in_ch.pos_y;
      cen_x_r <= in_ch.center_x;
      cen_y_r <= in_ch.center_y;
    end
    sw_r       <= sw_nxt;
    sh_r       <= sh_nxt;
    stride_r   <= stride_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    j_r        <= j_nxt;
    sy_r       <= sy_nxt;
    ry_r       <= ry_nxt;
    row_base_r <= row_base_nxt;
    i_r        <= i_nxt;
    sx_r       <= sx_nxt;
    rx_r       <= rx_nxt;
    mask_r     <= mask_nxt;
    if (issue) begin
      pidx_r  <= i_r[IDX_W-1:0];
      pbsel_r <= sx_r[2:0];
    end
    if (op == OP_EMIT && out_free) begin
      row_y_r   <= y0_r + COORD_W'(j_r);
      start_x_r <= x0_r;
      pmask_r   <= mask_r;
      color_r   <= cfg.draw_color;
      last_r    <= last_row;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_y       = row_y_r;
  assign out_ch.start_x     = start_x_r;
  assign out_ch.pixel_mask  = pmask_r;
  assign out_ch.pixel_color = color_r;
  assign out_ch.last        = last_r;

endmodule

// ===== hdl/scaled_mono_bitmap_blitter.sv =====
// Top level of the scaled mono bitmap blitter: configuration registers,
// microcode sequencer and datapath. Depends on smbb_pkg, smbb_ifs, smbb_useq, smbb_dpath.
//
// in_ch takes words of two kinds. mode 0 writes byte_value to the bitmap
// store at byte_index and gives no result. mode 1 starts a draw
// of the stored bitmap scaled by scale_q8, placed at pos_x/pos_y or centered.
// out_ch gives one word per scaled row, top to bottom, with a 64-bit pixel
// mask; last marks the final row. A draw whose scaled size is zero gives none.
// cfg_we/cfg_index/cfg_wdata write the six configuration registers; write
// them only while no draw is running.
// The bitmap store is read one byte per output pixel. in_ch.ready is high
// only between draws. The result register holds a row while the receiver
// stalls; the next row is built behind it and waits for the register to free.
// Reset (rst_n low at a clock edge) restores the register defaults and drops
// any draw in progress; the bitmap store keeps its contents.
module scaled_mono_bitmap_blitter (
  input  logic                           clk,
  input  logic                           rst_n,
  smbb_in_if.sink                        in_ch,
  smbb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [smbb_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [smbb_pkg::CDATA_W-1:0]   cfg_wdata
);
  import smbb_pkg::*;

  cfg_t  cfg_r;
  op_t   op;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_WIDTH:  cfg_r.display_width  <= cfg_wdata[DISP_W-1:0];
        REG_DISPLAY_HEIGHT: cfg_r.display_height <= cfg_wdata[DISP_W-1:0];
        REG_BITMAP_WIDTH:   cfg_r.bitmap_width   <= cfg_wdata[DIM_W-1:0];
        REG_BITMAP_HEIGHT:  cfg_r.bitmap_height  <= cfg_wdata[DIM_W-1:0];
        REG_SCALE_Q8:       cfg_r.scale_q8       <= cfg_wdata[SCALE_W-1:0];
        REG_DRAW_COLOR:     cfg_r.draw_color     <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  smbb_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  smbb_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .op     (op),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== hdl/smbb_checker.sv =====
// Port-level checks for scaled_mono_bitmap_blitter, attached by bind.
// Depends on smbb_pkg and the top level's ports.
module smbb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_last,
  input logic [smbb_pkg::COORD_W-1:0]      out_row_y,
  input logic [smbb_pkg::MASK_W-1:0]       out_pixel_mask
);
  import smbb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_y) && $stable(out_pixel_mask))
    else $error("result word changed while stalled");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input still ready after draw start");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("byte load left the block busy");

  a_mid_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a draw still has rows");

endmodule

bind scaled_mono_bitmap_blitter smbb_checker u_smbb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_mode        (in_ch.mode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_last       (out_ch.last),
  .out_row_y      (out_ch.row_y),
  .out_pixel_mask (out_ch.pixel_mask)
);

// ===== test/tb_scaled_mono_bitmap_blitter.sv =====
// Self-checking bench for the scaled mono bitmap blitter: table-driven and random
// load and draw words, checked row by row against an in-bench scaling predictor.
// Depends on smbb_pkg, smbb_ifs and the blitter RTL.
module tb_scaled_mono_bitmap_blitter;
  timeunit 1ns;
  timeprecision 1ps;
  import smbb_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_INVERT = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_RSVD   = 2'd3;

  localparam int IDLE_PCT    = 26;
  localparam int ITEM_TARGET = 320;
  localparam int PLAN_LEN    = 19;

  typedef struct packed {
    logic [DISP_W-1:0]  dw;
    logic [DISP_W-1:0]  dh;
    logic [DIM_W-1:0]   bw;
    logic [DIM_W-1:0]   bh;
    logic [SCALE_W-1:0] sc;
    logic [COLOR_W-1:0] col;
  } setup_t;

  typedef struct packed {
    logic                      mode;
    logic [ADDR_W-1:0]         byte_index;
    logic [BYTE_W-1:0]         byte_value;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      center_x;
    logic                      center_y;
  } blit_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] row_y;
    logic signed [COORD_W-1:0] start_x;
    logic [MASK_W-1:0]         pixel_mask;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last;
  } row_t;

  typedef struct packed {
    logic       reconf;
    setup_t     setup;
    blit_word_t word;
    logic       known;
    row_t       want;
  } step_t;

  localparam setup_t NO_SETUP = '0;
  localparam row_t   NO_ROW   = '0;

  localparam setup_t S_ONE_ROW    = '{9'd128, 9'd64, 7'd8, 7'd1, 12'd256, COLOR_WHITE};
  localparam setup_t S_TINY_BIG   = '{9'd0, 9'd511, 7'd0, 7'd0, 12'd4095, COLOR_RSVD};
  localparam setup_t S_WIDE       = '{9'd256, 9'd1, 7'd127, 7'd1, 12'd256, COLOR_BLACK};
  localparam setup_t S_ZERO_SCALE = '{9'd128, 9'd64, 7'd8, 7'd8, 12'd0, COLOR_WHITE};
  localparam setup_t S_THIN       = '{9'd128, 9'd64, 7'd64, 7'd1, 12'd1, COLOR_INVERT};
  localparam setup_t S_HALF       = '{9'd200, 9'd100, 7'd8, 7'd2, 12'd128, COLOR_WHITE};
  localparam setup_t S_WRAP       = '{9'd1, 9'd1, 7'd8, 7'd4, 12'd256, COLOR_INVERT};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDATA_W-1:0]  cfg_wdata;

  smbb_in_if  in_if ();
  smbb_out_if out_if ();

  scaled_mono_bitmap_blitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [BYTE_W-1:0] bitmap_copy [STORE_BYTES];
  bit                written [STORE_BYTES];
  setup_t            active_setup;
  row_t              rows_due [$];
  int                mismatches = 0;
  int                words_sent = 0;
  int                src_idle = IDLE_PCT;
  int                sink_idle = IDLE_PCT;

  function automatic blit_word_t ld(input int idx, input int val);
    blit_word_t w;
    w = '0;
    w.mode = MODE_LOAD;
    w.byte_index = ADDR_W'(idx);
    w.byte_value = BYTE_W'(val);
    return w;
  endfunction

  function automatic blit_word_t dr(input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py,
                                    input logic cx, input logic cy);
    blit_word_t w;
    w = '0;
    w.mode = MODE_DRAW;
    w.pos_x = px;
    w.pos_y = py;
    w.center_x = cx;
    w.center_y = cy;
    return w;
  endfunction

  step_t plan [PLAN_LEN] = '{
    '{1'b1, S_ONE_ROW, ld(0, 8'h80), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(16'sd0, 16'sd0, 1'b0, 1'b0), 1'b1,
      '{16'sd0, 16'sd0, 64'h1, COLOR_WHITE, 1'b1}},
    '{1'b0, NO_SETUP, ld(0, 8'hFF), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(16'h8000, 16'h7FFF, 1'b0, 1'b0), 1'b1,
      '{16'h7FFF, 16'h8000, 64'hFF, COLOR_WHITE, 1'b1}},
    '{1'b0, NO_SETUP, ld(0, 8'h01), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(16'h7FFF, 16'h8000, 1'b0, 1'b0), 1'b1,
      '{16'h8000, 16'h7FFF, 64'h80, COLOR_WHITE, 1'b1}},
    '{1'b0, NO_SETUP, dr(16'sd0, 16'sd0, 1'b1, 1'b1), 1'b1,
      '{16'sd31, 16'sd60, 64'h80, COLOR_WHITE, 1'b1}},
    '{1'b0, NO_SETUP, ld(511, 8'hFF), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, ld(511, 8'h00), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, ld(0, 8'hA5), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(16'sd0, -16'sd1, 1'b1, 1'b0), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(-16'sd1, 16'sd0, 1'b0, 1'b1), 1'b0, NO_ROW},
    '{1'b1, S_TINY_BIG, dr(16'sd0, 16'sd0, 1'b1, 1'b1), 1'b0, NO_ROW},
    '{1'b1, S_WIDE, dr(16'sd0, 16'sd0, 1'b1, 1'b1), 1'b0, NO_ROW},
    '{1'b1, S_ZERO_SCALE, dr(16'sd5, 16'sd5, 1'b0, 1'b0), 1'b0, NO_ROW},
    '{1'b1, S_THIN, dr(16'sd5, 16'sd5, 1'b1, 1'b1), 1'b0, NO_ROW},
    '{1'b1, S_HALF, dr(16'h7FFF, 16'h7FFF, 1'b0, 1'b0), 1'b0, NO_ROW},
    '{1'b1, S_WRAP, dr(16'sd100, 16'sd32766, 1'b0, 1'b0), 1'b0, NO_ROW},
    '{1'b0, NO_SETUP, dr(16'sd0, 16'sd0, 1'b1, 1'b1), 1'b0, NO_ROW}
  };

  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_SRC_DIM) return MAX_SRC_DIM;
    return int'(d);
  endfunction

  function automatic int out_span(input int d);
    int s;
    s = (d * int'(active_setup.sc)) / 256;
    return (s > MAX_OUT_DIM) ? MAX_OUT_DIM : s;
  endfunction

  function automatic int back_map(input int i, input int dim);
    int s;
    s = (i * 256) / int'(active_setup.sc);
    return (s >= dim) ? dim - 1 : s;
  endfunction

  function automatic int region_bytes();
    return ((eff_dim(active_setup.bw) + 7) / 8) * eff_dim(active_setup.bh);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int k;
    k = $urandom_range(99);
    if (k < 5) return '0;
    if (k < 12) return DIM_W'($urandom_range(64, 127));
    return DIM_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [DISP_W-1:0] pick_disp();
    int k;
    k = $urandom_range(99);
    if (k < 4) return '0;
    if (k < 8) return DISP_W'($urandom_range(257, 511));
    return DISP_W'($urandom_range(1, 256));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic rasterize_rows(input blit_word_t w);
    int   bw;
    int   bh;
    int   sw;
    int   sh;
    int   stride;
    int   x0;
    int   y0;
    int   sx;
    int   sy;
    int   addr;
    row_t r;
    bw = eff_dim(active_setup.bw);
    bh = eff_dim(active_setup.bh);
    sw = out_span(bw);
    sh = out_span(bh);
    if (sw == 0 || sh == 0) return;
    stride = (bw + 7) / 8;
    x0 = w.center_x ? (int'(active_setup.dw) - sw) / 2 : int'(w.pos_x);
    y0 = w.center_y ? (int'(active_setup.dh) - sh) / 2 : int'(w.pos_y);
    for (int j = 0; j < sh; j++) begin
      sy = back_map(j, bh);
      r = '0;
      for (int i = 0; i < sw; i++) begin
        sx = back_map(i, bw);
        addr = sy * stride + sx / 8;
        if (addr < STORE_BYTES && bitmap_copy[addr][7 - sx % 8]) r.pixel_mask[i] = 1'b1;
      end
      r.row_y = COORD_W'(y0 + j);
      r.start_x = COORD_W'(x0);
      r.pixel_color = active_setup.col;
      r.last = (j == sh - 1);
      rows_due.push_back(r);
    end
  endtask

  task automatic push_word(input blit_word_t w, input bit apply_rows);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.mode = w.mode;
    in_if.byte_index = w.byte_index;
    in_if.byte_value = w.byte_value;
    in_if.pos_x = w.pos_x;
    in_if.pos_y = w.pos_y;
    in_if.center_x = w.center_x;
    in_if.center_y = w.center_y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
    if (w.mode == MODE_LOAD) begin
      bitmap_copy[w.byte_index] = w.byte_value;
      written[w.byte_index] = 1'b1;
    end else if (apply_rows) begin
      rasterize_rows(w);
    end
    @(negedge clk);
  endtask

  task automatic cover_region();
    for (int a = 0; a < region_bytes(); a++)
      if (!written[a]) push_word(ld(a, $urandom_range(0, 255)), 1'b1);
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (rows_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    while (!in_if.ready) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CIDX_W-1:0] idx, input int val, input int width);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CDATA_W'(($urandom() << width) | val);
    @(negedge clk);
  endtask

  task automatic write_setup(input setup_t s);
    put_reg(REG_DISPLAY_WIDTH, int'(s.dw), DISP_W);
    put_reg(REG_DISPLAY_HEIGHT, int'(s.dh), DISP_W);
    put_reg(REG_BITMAP_WIDTH, int'(s.bw), DIM_W);
    put_reg(REG_BITMAP_HEIGHT, int'(s.bh), DIM_W);
    put_reg(REG_SCALE_Q8, int'(s.sc), SCALE_W);
    put_reg(REG_DRAW_COLOR, int'(s.col), COLOR_W);
    cfg_we = 1'b0;
    active_setup = s;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_if.ready = ($urandom_range(99) >= sink_idle);

  always @(posedge clk) begin : watch
    row_t got;
    row_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.row_y, out_if.start_x, out_if.pixel_mask, out_if.pixel_color,
              out_if.last};
      if (rows_due.size() == 0) begin
        report_mismatch("row with none due", got.pixel_mask, '0);
      end else begin
        want = rows_due.pop_front();
        if (got.row_y !== want.row_y)
          report_mismatch("row_y", 64'(got.row_y), 64'(want.row_y));
        if (got.start_x !== want.start_x)
          report_mismatch("start_x", 64'(got.start_x), 64'(want.start_x));
        if (got.pixel_mask !== want.pixel_mask)
          report_mismatch("pixel_mask", got.pixel_mask, want.pixel_mask);
        if (got.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", 64'(got.pixel_color), 64'(want.pixel_color));
        if (got.last !== want.last)
          report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    int         phase;
    int         count;
    int         k;
    setup_t     s;
    blit_word_t w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_LOAD;
    in_if.byte_index = '0;
    in_if.byte_value = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.center_x = 1'b0;
    in_if.center_y = 1'b0;
    out_if.ready = 1'b0;
    active_setup = '{9'd128, 9'd64, 7'd64, 7'd64, 12'd256, COLOR_WHITE};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].reconf) begin
        settle();
        write_setup(plan[i].setup);
      end
      if (plan[i].word.mode == MODE_DRAW) cover_region();
      if (plan[i].known) rows_due.push_back(plan[i].want);
      push_word(plan[i].word, !plan[i].known);
    end

    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      settle();
      src_idle = (phase == 2) ? 0 : IDLE_PCT;
      sink_idle = (phase == 2) ? 0 : IDLE_PCT;
      s.dw = pick_disp();
      s.dh = pick_disp();
      s.bw = pick_dim();
      s.bh = pick_dim();
      k = $urandom_range(99);
      if (k < 4) s.sc = '0;
      else if (k < 10) s.sc = SCALE_W'($urandom_range(1, 63));
      else if (k < 18) s.sc = SCALE_W'($urandom_range(1024, 4095));
      else s.sc = SCALE_W'($urandom_range(64, 640));
      s.col = COLOR_W'($urandom_range(0, 3));
      write_setup(s);
      count = (phase == 2) ? 40 : $urandom_range(6, 20);
      repeat (count) begin
        w.pos_x = COORD_W'($urandom());
        w.pos_y = COORD_W'($urandom());
        if ($urandom_range(99) < 10) w.pos_x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        if ($urandom_range(99) < 10) w.pos_y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        w.center_x = ($urandom_range(99) < 35);
        w.center_y = ($urandom_range(99) < 35);
        w.byte_value = BYTE_W'($urandom());
        if ($urandom_range(99) < 70) w.byte_index = ADDR_W'($urandom_range(0, region_bytes() - 1));
        else w.byte_index = ADDR_W'($urandom_range(0, STORE_BYTES - 1));
        if ($urandom_range(99) < 40) begin
          w.mode = MODE_DRAW;
          cover_region();
        end else begin
          w.mode = MODE_LOAD;
        end
        push_word(w, 1'b1);
      end
      phase++;
    end

    in_if.valid = 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/smbb_pkg.sv
hdl/smbb_ifs.sv
hdl/smbb_useq.sv
hdl/smbb_dpath.sv
hdl/scaled_mono_bitmap_blitter.sv
hdl/smbb_checker.sv
test/tb_scaled_mono_bitmap_blitter.sv
